>>> rtl/ath_pkg.sv
// Package with shared types, constants and the address hash constants for the allocation tracker.
`default_nettype none
package ath_pkg;
    localparam int unsigned TABLE_SLOTS = 4096;
    localparam int unsigned IDX_W = $clog2(TABLE_SLOTS);
    localparam int unsigned CNT_W = $clog2(TABLE_SLOTS + 1);
    localparam int unsigned QDEPTH = 2;
    localparam logic [31:0] KEY_EMPTY = 32'd0;
    localparam logic [31:0] KEY_TOMB = 32'd1;
    localparam logic [63:0] SAT64 = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] MIX_A = 32'h7feb352d;
    localparam logic [31:0] MIX_B = 32'h846ca68b;

    typedef enum logic [2:0] {
        OP_ALLOC = 3'd0,
        OP_ZALLOC = 3'd1,
        OP_RESIZE = 3'd2,
        OP_FREE = 3'd3,
        OP_RUNRST = 3'd4
    } opcode_t;

    typedef struct packed {
        logic [2:0] opcode;
        logic [31:0] address;
        logic [31:0] new_address;
        logic [31:0] alloc_size;
        logic [31:0] element_count;
    } in_beat_t;

    typedef struct packed {
        logic recorded;
        logic removed;
        logic [63:0] current_delta_bytes;
        logic [63:0] peak_delta_bytes;
        logic [63:0] run_alloc_count;
        logic [63:0] run_free_count;
        logic [63:0] run_dropped_count;
    } out_beat_t;

    // Classified command handed from the front end to the table engine.
    typedef struct packed {
        logic do_release;
        logic do_record;
        logic do_runrst;
        logic [31:0] rel_addr;
        logic [31:0] rec_addr;
        logic [31:0] rec_bytes;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLEAR, ST_MUL1, ST_MUL2, ST_HOME, ST_RD, ST_CHK,
        ST_WRITE, ST_RESULT, ST_OUT
    } eng_state_t;

    function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? SAT64 : s[63:0];
    endfunction

    function automatic logic [63:0] sub_floor(input logic [63:0] a, input logic [63:0] b);
        return (a >= b) ? (a - b) : 64'd0;
    endfunction
endpackage
`default_nettype wire

>>> rtl/ath_front.sv
// Front end: accepts beats, forms the zeroed size and classifies each event into a command.
`default_nettype none
module ath_front
    import ath_pkg::*;
(
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    output logic s_ready,
    input wire in_beat_t s_data,
    output logic q_valid,
    input wire logic q_ready,
    output cmd_t q_cmd
);
    in_beat_t beat_reg;
    logic stage_reg;
    logic [63:0] prod_reg;
    cmd_t fifo_reg [QDEPTH];
    logic [$clog2(QDEPTH)-1:0] wp_reg, rp_reg;
    logic [$clog2(QDEPTH+1)-1:0] cnt_reg;
    logic push, pop;
    cmd_t cmd;
    logic [31:0] zbytes;

    assign s_ready = !stage_reg;
    assign zbytes = (prod_reg[63:32] != 32'd0) ? 32'hFFFF_FFFF : prod_reg[31:0];

    always_comb begin
        cmd = '0;
        cmd.rel_addr = beat_reg.address;
        cmd.rec_addr = beat_reg.address;
        cmd.rec_bytes = beat_reg.alloc_size;
        case (beat_reg.opcode)
            OP_ALLOC: cmd.do_record = beat_reg.address != 32'd0;
            OP_ZALLOC: begin
                cmd.do_record = beat_reg.address != 32'd0;
                cmd.rec_bytes = zbytes;
            end
            OP_RESIZE: begin
                if (!(beat_reg.new_address == 32'd0 && beat_reg.alloc_size != 32'd0)) begin
                    cmd.do_release = beat_reg.address != 32'd0;
                    cmd.do_record = beat_reg.new_address != 32'd0;
                    cmd.rec_addr = beat_reg.new_address;
                end
            end
            OP_FREE: cmd.do_release = beat_reg.address != 32'd0;
            OP_RUNRST: cmd.do_runrst = 1'b1;
            default: ;
        endcase
    end

    assign push = stage_reg && (cnt_reg != QDEPTH[$clog2(QDEPTH+1)-1:0]);
    assign pop = q_valid && q_ready;
    assign q_valid = cnt_reg != '0;
    assign q_cmd = fifo_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= 1'b0;
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (s_valid && s_ready) begin
                stage_reg <= 1'b1;
            end else if (push) begin
                stage_reg <= 1'b0;
            end
            if (push) begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop) begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + {{($clog2(QDEPTH+1)-1){1'b0}}, push}
                       - {{($clog2(QDEPTH+1)-1){1'b0}}, pop};
        end
        if (s_valid && s_ready) begin
            beat_reg <= s_data;
            prod_reg <= 64'(s_data.element_count) * 64'(s_data.alloc_size);
        end
        if (push) begin
            fifo_reg[wp_reg] <= cmd;
        end
    end
endmodule
`default_nettype wire

>>> rtl/ath_engine.sv
// Back end: hash, probe and update the slot table, keep the counters and emit results.
`default_nettype none
module ath_engine
    import ath_pkg::*;
(
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic q_valid,
    output logic q_ready,
    input wire cmd_t q_cmd,
    output logic m_valid,
    input wire logic m_ready,
    output out_beat_t m_data
);
    logic [31:0] key_mem [TABLE_SLOTS];
    logic [31:0] bytes_mem [TABLE_SLOTS];
    logic [31:0] rd_key_reg, rd_bytes_reg;

    eng_state_t state_reg, state_next;
    cmd_t cmd_reg;
    logic phase_reg, phase_next;
    logic [31:0] x_reg, x_next;
    logic [IDX_W-1:0] idx_reg, idx_next, tomb_reg, tomb_next, clr_reg, clr_next;
    logic tomb_ok_reg, tomb_ok_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic rec_reg, rec_next, rem_reg, rem_next;
    logic [63:0] live_reg, live_next, alloc_reg, alloc_next, free_reg, free_next;
    logic [63:0] drop_reg, drop_next, base_reg, base_next, peak_reg, peak_next;
    logic [63:0] abase_reg, abase_next, fbase_reg, fbase_next, dbase_reg, dbase_next;
    logic [31:0] wbytes_reg, wbytes_next;
    out_beat_t out_reg, out_next;
    logic out_v_reg, out_v_next;
    logic [63:0] mul;
    logic [31:0] mixed, cur_addr;
    logic [IDX_W-1:0] idx_inc;
    logic we;
    logic [IDX_W-1:0] waddr;
    logic [31:0] wkey, wbytes;

    assign q_ready = (state_reg == ST_IDLE) && !out_v_reg;
    assign m_valid = out_v_reg;
    assign m_data = out_reg;
    assign cur_addr = phase_reg ? cmd_reg.rec_addr : cmd_reg.rel_addr;
    assign mul = 64'(x_reg) * 64'((state_reg == ST_MUL1) ? MIX_A : MIX_B);
    assign mixed = x_reg ^ (x_reg >> 16);
    assign idx_inc = (32'(idx_reg) + 32'd1 >= TABLE_SLOTS) ? '0 : idx_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (we) begin
            key_mem[waddr] <= wkey;
            bytes_mem[waddr] <= wbytes;
        end
        rd_key_reg <= key_mem[idx_reg];
        rd_bytes_reg <= bytes_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            out_v_reg <= 1'b0;
            live_reg <= '0; alloc_reg <= '0; free_reg <= '0; drop_reg <= '0;
            base_reg <= '0; peak_reg <= '0; abase_reg <= '0; fbase_reg <= '0;
            dbase_reg <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            out_v_reg <= out_v_next;
            live_reg <= live_next; alloc_reg <= alloc_next; free_reg <= free_next;
            drop_reg <= drop_next; base_reg <= base_next; peak_reg <= peak_next;
            abase_reg <= abase_next; fbase_reg <= fbase_next; dbase_reg <= dbase_next;
        end
        if (q_valid && q_ready) begin
            cmd_reg <= q_cmd;
        end
        phase_reg <= phase_next; x_reg <= x_next; idx_reg <= idx_next;
        tomb_reg <= tomb_next; tomb_ok_reg <= tomb_ok_next; n_reg <= n_next;
        rec_reg <= rec_next; rem_reg <= rem_next; wbytes_reg <= wbytes_next;
        out_reg <= out_next;
    end

    always_comb begin
        state_next = state_reg; clr_next = clr_reg; phase_next = phase_reg;
        x_next = x_reg; idx_next = idx_reg; tomb_next = tomb_reg;
        tomb_ok_next = tomb_ok_reg; n_next = n_reg; rec_next = rec_reg;
        rem_next = rem_reg; wbytes_next = wbytes_reg; out_next = out_reg;
        out_v_next = out_v_reg && !m_ready;
        live_next = live_reg; alloc_next = alloc_reg; free_next = free_reg;
        drop_next = drop_reg; base_next = base_reg; peak_next = peak_reg;
        abase_next = abase_reg; fbase_next = fbase_reg; dbase_next = dbase_reg;
        we = 1'b0; waddr = idx_reg; wkey = KEY_EMPTY; wbytes = 32'd0;
        unique case (state_reg)
            ST_CLEAR: begin
                we = 1'b1;
                waddr = clr_reg;
                if (32'(clr_reg) == TABLE_SLOTS - 1) begin
                    state_next = ST_IDLE;
                end
                clr_next = clr_reg + 1'b1;
            end
            ST_IDLE: begin
                if (q_valid && q_ready) begin
                    rec_next = 1'b0;
                    rem_next = 1'b0;
                    if (q_cmd.do_runrst) begin
                        base_next = live_reg; peak_next = live_reg;
                        abase_next = alloc_reg; fbase_next = free_reg;
                        dbase_next = drop_reg;
                        state_next = ST_RESULT;
                    end else if (q_cmd.do_release) begin
                        phase_next = 1'b0;
                        x_next = q_cmd.rel_addr ^ (q_cmd.rel_addr >> 16);
                        state_next = (q_cmd.rel_addr == KEY_TOMB) ? ST_WRITE : ST_MUL1;
                        wbytes_next = 32'd0;
                    end else if (q_cmd.do_record) begin
                        phase_next = 1'b1;
                        x_next = q_cmd.rec_addr ^ (q_cmd.rec_addr >> 16);
                        state_next = (q_cmd.rec_addr == KEY_TOMB) ? ST_WRITE : ST_MUL1;
                    end else begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_MUL1: begin
                x_next = mul[31:0] ^ (mul[31:0] >> 15);
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                x_next = mul[31:0];
                state_next = ST_HOME;
            end
            ST_HOME: begin
                idx_next = IDX_W'(mixed % TABLE_SLOTS);
                n_next = '0;
                tomb_ok_next = 1'b0;
                state_next = ST_RD;
            end
            ST_RD: state_next = ST_CHK;
            ST_CHK: begin
                state_next = ST_RD;
                idx_next = idx_inc;
                n_next = n_reg + 1'b1;
                if (rd_key_reg == cur_addr) begin
                    tomb_ok_next = 1'b1;
                    tomb_next = idx_reg;
                    wbytes_next = rd_bytes_reg;
                    state_next = ST_WRITE;
                    if (!phase_reg) begin
                        rem_next = 1'b1;
                    end
                end else if (rd_key_reg == KEY_EMPTY) begin
                    if (!tomb_ok_reg && phase_reg) begin
                        tomb_ok_next = 1'b1;
                        tomb_next = idx_reg;
                    end
                    state_next = ST_WRITE;
                end else begin
                    if (rd_key_reg == KEY_TOMB && !tomb_ok_reg && phase_reg) begin
                        tomb_ok_next = 1'b1;
                        tomb_next = idx_reg;
                    end
                    if (32'(n_reg) + 32'd1 >= TABLE_SLOTS) begin
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_WRITE: begin
                if (!phase_reg) begin
                    if (rem_reg) begin
                        we = 1'b1; waddr = tomb_reg; wkey = KEY_TOMB;
                        live_next = sub_floor(live_reg, 64'(wbytes_reg));
                    end
                    free_next = add_sat(free_reg, 64'd1);
                    if (cmd_reg.do_record) begin
                        phase_next = 1'b1;
                        x_next = cmd_reg.rec_addr ^ (cmd_reg.rec_addr >> 16);
                        state_next = (cmd_reg.rec_addr == KEY_TOMB) ? ST_WRITE : ST_MUL1;
                    end else begin
                        state_next = ST_RESULT;
                    end
                end else begin
                    alloc_next = add_sat(alloc_reg, 64'd1);
                    if (cmd_reg.rec_addr != KEY_TOMB) begin
                        if (tomb_ok_reg) begin
                            we = 1'b1; waddr = tomb_reg; wkey = cmd_reg.rec_addr;
                            wbytes = cmd_reg.rec_bytes;
                            rec_next = 1'b1;
                            live_next = add_sat(live_reg, 64'(cmd_reg.rec_bytes));
                            if (live_next > peak_reg) begin
                                peak_next = live_next;
                            end
                        end else begin
                            drop_next = add_sat(drop_reg, 64'd1);
                        end
                    end
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                out_next.recorded = rec_reg;
                out_next.removed = rem_reg;
                out_next.current_delta_bytes = sub_floor(live_reg, base_reg);
                out_next.peak_delta_bytes = sub_floor(peak_reg, base_reg);
                out_next.run_alloc_count = sub_floor(alloc_reg, abase_reg);
                out_next.run_free_count = sub_floor(free_reg, fbase_reg);
                out_next.run_dropped_count = sub_floor(drop_reg, dbase_reg);
                out_v_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

>>> rtl/allocation_tracker_hash_table_core.sv
// Top level of the allocation tracker: front end, command queue and table engine.
//   Channel | Ports           | Dir | Beat
//   input   | s_valid/s_ready | in  | in_beat_t s_data
//   result  | m_valid/m_ready | out | out_beat_t m_data
// Each probed slot takes a table read state and a check state, set by the single table
// read port. Null, unused and run reset events go straight to the result state.
// Resize can run two probe walks. A free or unknown event ends at the first empty slot.
// After reset all 4096 slots of the key table are cleared; up to three beats are taken
// meanwhile and wait in the front end.
// Input beats are taken while a result waits; the queue holds two commands.
`default_nettype none
module allocation_tracker_hash_table_core
    import ath_pkg::*;
(
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    output logic s_ready,
    input wire in_beat_t s_data,
    output logic m_valid,
    input wire logic m_ready,
    output out_beat_t m_data
);
    logic q_valid, q_ready;
    cmd_t q_cmd;

    ath_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_data(s_data), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    ath_engine u_engine (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_ready(q_ready),
        .q_cmd(q_cmd), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );
endmodule
`default_nettype wire

>>> sim/allocation_tracker_hash_table_core_tb.sv
// Testbench for the allocation tracker hash table core with a scoreboard class and a table model.
`timescale 1ns / 1ps
module allocation_tracker_hash_table_core_tb;
    import ath_pkg::*;

    class alloc_scoreboard;
        logic [31:0] key_mem [TABLE_SLOTS];
        logic [31:0] size_mem [TABLE_SLOTS];
        logic [63:0] live_bytes, peak_bytes, alloc_total, free_total, dropped_total;
        logic [63:0] base_bytes, base_alloc, base_free, base_dropped;
        out_beat_t pending_results[$];
        int mismatches;

        function new();
            foreach (key_mem[i]) begin
                key_mem[i] = KEY_EMPTY;
                size_mem[i] = 32'd0;
            end
            live_bytes = 0; peak_bytes = 0; alloc_total = 0; free_total = 0;
            dropped_total = 0; base_bytes = 0; base_alloc = 0; base_free = 0;
            base_dropped = 0; mismatches = 0;
        endfunction

        function int home_slot(logic [31:0] a);
            logic [31:0] x;
            x = a;
            x = x ^ (x >> 16);
            x = x * MIX_A;
            x = x ^ (x >> 15);
            x = x * MIX_B;
            x = x ^ (x >> 16);
            return int'(x % TABLE_SLOTS);
        endfunction

        function bit store_block(logic [31:0] a, logic [31:0] bytes);
            int idx, tomb, n, slot;
            logic [64:0] sum;
            bit ok;
            ok = 0;
            slot = -1;
            if (a > KEY_TOMB) begin
                idx = home_slot(a);
                tomb = -1;
                for (n = 0; n < TABLE_SLOTS; n++) begin
                    if (key_mem[idx] == a) begin
                        slot = idx;
                        break;
                    end
                    if (key_mem[idx] == KEY_EMPTY) begin
                        slot = (tomb >= 0) ? tomb : idx;
                        break;
                    end
                    if (key_mem[idx] == KEY_TOMB && tomb < 0) tomb = idx;
                    idx = (idx + 1) % TABLE_SLOTS;
                end
                if (n == TABLE_SLOTS) slot = tomb;
                if (slot < 0) begin
                    if (dropped_total != SAT64) dropped_total++;
                end else begin
                    key_mem[slot] = a;
                    size_mem[slot] = bytes;
                    ok = 1;
                end
            end
            if (alloc_total != SAT64) alloc_total++;
            if (ok) begin
                sum = {1'b0, live_bytes} + {33'd0, bytes};
                live_bytes = sum[64] ? SAT64 : sum[63:0];
                if (live_bytes > peak_bytes) peak_bytes = live_bytes;
            end
            return ok;
        endfunction

        function bit drop_block(logic [31:0] a);
            int idx, n;
            logic [31:0] bytes;
            bit hit;
            bytes = 0;
            hit = 0;
            if (a > KEY_TOMB) begin
                idx = home_slot(a);
                for (n = 0; n < TABLE_SLOTS; n++) begin
                    if (key_mem[idx] == a) begin
                        bytes = size_mem[idx];
                        key_mem[idx] = KEY_TOMB;
                        size_mem[idx] = 0;
                        hit = 1;
                        break;
                    end
                    if (key_mem[idx] == KEY_EMPTY) break;
                    idx = (idx + 1) % TABLE_SLOTS;
                end
            end
            if (free_total != SAT64) free_total++;
            live_bytes = (live_bytes >= bytes) ? live_bytes - bytes : 64'd0;
            return hit;
        endfunction

        function logic [63:0] floor_diff(logic [63:0] a, logic [63:0] b);
            return (a >= b) ? a - b : 64'd0;
        endfunction

        function void note_event(in_beat_t ev);
            out_beat_t r;
            logic [63:0] prod;
            r = '0;
            case (ev.opcode)
                OP_ALLOC: if (ev.address != 0) r.recorded = store_block(ev.address, ev.alloc_size);
                OP_ZALLOC: if (ev.address != 0) begin
                    prod = {32'd0, ev.element_count} * {32'd0, ev.alloc_size};
                    r.recorded = store_block(ev.address,
                        (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0]);
                end
                OP_RESIZE: if (!(ev.new_address == 0 && ev.alloc_size != 0)) begin
                    if (ev.address != 0) r.removed = drop_block(ev.address);
                    if (ev.new_address != 0)
                        r.recorded = store_block(ev.new_address, ev.alloc_size);
                end
                OP_FREE: if (ev.address != 0) r.removed = drop_block(ev.address);
                OP_RUNRST: begin
                    base_bytes = live_bytes; peak_bytes = live_bytes;
                    base_alloc = alloc_total; base_free = free_total;
                    base_dropped = dropped_total;
                end
                default: ;
            endcase
            r.current_delta_bytes = floor_diff(live_bytes, base_bytes);
            r.peak_delta_bytes = floor_diff(peak_bytes, base_bytes);
            r.run_alloc_count = floor_diff(alloc_total, base_alloc);
            r.run_free_count = floor_diff(free_total, base_free);
            r.run_dropped_count = floor_diff(dropped_total, base_dropped);
            pending_results.push_back(r);
        endfunction

        function void check_result(out_beat_t got);
            out_beat_t want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result beat %h", got);
                return;
            end
            want = pending_results.pop_front();
            if (got.recorded !== want.recorded || got.removed !== want.removed
                    || got.current_delta_bytes !== want.current_delta_bytes
                    || got.peak_delta_bytes !== want.peak_delta_bytes
                    || got.run_alloc_count !== want.run_alloc_count
                    || got.run_free_count !== want.run_free_count
                    || got.run_dropped_count !== want.run_dropped_count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected %h, actual %h", want, got);
            end
        endfunction
    endclass

    logic aclk, aresetn, s_valid, s_ready, m_valid, m_ready;
    in_beat_t s_data;
    out_beat_t m_data;
    alloc_scoreboard sb;
    logic [31:0] live_addrs[$];
    bit drive_done;

    allocation_tracker_hash_table_core uut (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_data(s_data), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #60_000_000;
        $display("FAIL allocation_tracker_hash_table_core");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) sb.note_event(s_data);
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    initial begin
        int w;
        m_ready <= 0;
        @(posedge aclk);
        while (!drive_done || sb == null || sb.pending_results.size() != 0 || 1) begin
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            repeat (w) begin
                m_ready <= 0;
                @(posedge aclk);
            end
            m_ready <= 1;
            @(posedge aclk);
            while (!(m_valid && m_ready)) @(posedge aclk);
        end
    end

    task automatic send_event(logic [2:0] op, logic [31:0] a, logic [31:0] na,
                              logic [31:0] sz, logic [31:0] cnt);
        int w;
        w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        if (w > 0) begin
            s_valid <= 0;
            repeat (w) @(posedge aclk);
        end
        s_valid <= 1;
        s_data <= {op, a, na, sz, cnt};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic stop_input();
        s_valid <= 0;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 3);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 2);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int i, k, sel;
        logic [31:0] a, na;
        aresetn <= 0;
        s_valid <= 0;
        s_data <= '0;
        drive_done = 0;
        sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        send_event(OP_ALLOC, 32'h1000, 0, 32'hFFFF_FFFF, 0);
        send_event(OP_ALLOC, 32'hFFFF_FFFF, 0, 0, 0);
        send_event(OP_ALLOC, 0, 0, 5, 0);
        send_event(OP_ALLOC, KEY_TOMB, 0, 7, 0);
        send_event(OP_ALLOC, 32'h1000, 0, 20, 0);
        send_event(OP_ZALLOC, 32'h2000, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_event(OP_ZALLOC, 32'h3000, 0, 0, 9);
        send_event(OP_ZALLOC, 32'h4000, 0, 12, 10);
        send_event(OP_ZALLOC, 0, 0, 1, 1);
        send_event(OP_RESIZE, 32'h1000, 0, 8, 0);
        send_event(OP_RESIZE, 32'h1000, 32'h5000, 64, 0);
        send_event(OP_RESIZE, 32'h4000, 0, 0, 0);
        send_event(OP_RESIZE, 0, 32'h6000, 100, 0);
        send_event(OP_RESIZE, 32'h7777, 32'h5000, 3, 0);
        send_event(OP_FREE, 32'h2000, 0, 0, 0);
        send_event(OP_FREE, 32'h9999, 0, 0, 0);
        send_event(OP_FREE, 0, 0, 0, 0);
        send_event(OP_RUNRST, 0, 0, 0, 0);
        send_event(OP_FREE, 32'h5000, 0, 0, 0);
        send_event(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_event(3'd7, 0, 0, 0, 0);
        send_event(OP_RUNRST, 0, 0, 0, 0);
        stop_input();
        while (sb.pending_results.size() != 0) @(posedge aclk);
        for (i = 0; i < 1950; i++) begin
            sel = $urandom_range(0, 99);
            a = (live_addrs.size() > 0) ? live_addrs[$urandom_range(0, live_addrs.size() - 1)]
                                        : rand_word();
            if (sel < 35) begin
                na = $urandom | 32'h2;
                live_addrs.push_back(na);
                send_event(OP_ALLOC, na, rand_word(), rand_word(), rand_word());
            end else if (sel < 45) begin
                na = $urandom | 32'h2;
                live_addrs.push_back(na);
                send_event(OP_ZALLOC, na, rand_word(), rand_word(), rand_word());
            end else if (sel < 60) begin
                na = ($urandom_range(0, 7) == 0) ? 32'd0 : ($urandom | 32'h2);
                if (na != 0) live_addrs.push_back(na);
                send_event(OP_RESIZE, a, na, ($urandom_range(0, 3) == 0) ? 0 : rand_word(),
                           rand_word());
            end else if (sel < 85) begin
                send_event(OP_FREE, a, rand_word(), rand_word(), rand_word());
            end else if (sel < 88) begin
                send_event(OP_RUNRST, rand_word(), rand_word(), rand_word(), rand_word());
            end else if (sel < 93) begin
                send_event(OP_ALLOC, a, 0, rand_word(), 0);
            end else begin
                send_event(3'($urandom_range(0, 7)), rand_word(), rand_word(), rand_word(),
                           rand_word());
            end
            if (live_addrs.size() > 300) live_addrs.delete(0);
            if (i == 900) begin
                stop_input();
                while (sb.pending_results.size() != 0) @(posedge aclk);
            end
        end
        stop_input();
        drive_done = 1;
        k = 0;
        while (sb.pending_results.size() != 0 && k < 200000) begin
            @(posedge aclk);
            k++;
        end
        repeat (200) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("PASS allocation_tracker_hash_table_core");
        else
            $display("FAIL allocation_tracker_hash_table_core");
        $finish;
    end
endmodule
